[rtl/ray_triangle_hit_test_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ray/triangle hit test
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_HIT_TEST_TOP_MACROS_SVH
`define RAY_TRIANGLE_HIT_TEST_TOP_MACROS_SVH

// same-cycle implication
`define RTH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rth_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_pkg
// Types and constants of the ray/triangle hit test: fixed point widths of
// every intermediate, payload structs and the configuration register map.
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int COORD_W   = 16;             // coordinate width
    localparam int TAG_W     = 16;
    localparam int EPS_W     = 41;             // determinant threshold width
    localparam int CFG_DATA_W = EPS_W;         // widest register
    localparam int CFG_IDX_W = 3;

    localparam int EDGE_W = COORD_W + 1;       // edges and s = origin - v0
    localparam int PROD_W = 2 * EDGE_W;        // one cross product term
    localparam int CRS_W  = PROD_W + 1;        // cross product component
    localparam int LO_W   = EDGE_W;            // low slice of a cross component
    localparam int PART_W = 2 * EDGE_W + 1;    // partial product of a dot term
    localparam int PSUM_W = PART_W + 2;        // sum of three partials
    localparam int DOT_W  = PSUM_W + LO_W;     // det, u and v numerators

    localparam int NUM_STAGES = 6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CRS_W-1:0]   crs_t;
    typedef logic signed [PART_W-1:0]  part_t;
    typedef logic signed [PSUM_W-1:0]  psum_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic signed [DOT_W:0]     usum_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5,
        CFG_CULL     = 3'd6,
        CFG_EPSILON  = 3'd7
    } cfg_idx_t;

    localparam logic [EPS_W-1:0] EPS_RESET   = EPS_W'(17);
    localparam coord_t           DIR_Z_RESET = coord_t'(256);

    typedef struct packed {
        coord_t             origin_x;
        coord_t             origin_y;
        coord_t             origin_z;
        coord_t             dir_x;
        coord_t             dir_y;
        coord_t             dir_z;
        logic               cull_backfaces;
        logic [EPS_W-1:0]   det_epsilon;
    } cfg_t;

    typedef struct packed {
        coord_t             v0_x;
        coord_t             v0_y;
        coord_t             v0_z;
        coord_t             v1_x;
        coord_t             v1_y;
        coord_t             v1_z;
        coord_t             v2_x;
        coord_t             v2_y;
        coord_t             v2_z;
        logic [TAG_W-1:0]   tri_tag;
    } tri_in_t;

    typedef struct packed {
        logic               hit;
        logic [TAG_W-1:0]   hit_tag;
    } tri_out_t;

endpackage

[rtl/rth_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_pipe
// Six-stage hit test datapath: edges, cross product terms, cross products,
// split dot product partials, dot sums, sign-aware compare into the output
// register. Each stage holds its beat unless the stage after it is free.
// ----------------------------------------------------------------------------
module rth_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  rth_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  rth_pkg::tri_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rth_pkg::tri_out_t out_data
);
    import rth_pkg::*;

    // dot term a*c with c cut into a signed high slice and an unsigned low slice
    function automatic part_t mul_hi(edge_t a, crs_t c);
        return part_t'(a) * part_t'($signed(c[CRS_W-1:LO_W]));
    endfunction

    function automatic part_t mul_lo(edge_t a, crs_t c);
        return part_t'(a) * part_t'($signed({1'b0, c[LO_W-1:0]}));
    endfunction

    function automatic dot_t dot3(part_t h0, part_t h1, part_t h2,
                                  part_t l0, part_t l1, part_t l2);
        psum_t hs;
        psum_t ls;
        hs = psum_t'(h0) + psum_t'(h1) + psum_t'(h2);
        ls = psum_t'(l0) + psum_t'(l1) + psum_t'(l2);
        return (dot_t'(hs) <<< LO_W) + dot_t'(ls);
    endfunction

    // ---------------- handshake ----------------
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = in_valid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    // ---------------- stage 1: edges ----------------
    edge_t s1_e1_reg [3], s1_e2_reg [3], s1_s_reg [3];
    edge_t s1_e1_next [3], s1_e2_next [3], s1_s_next [3];
    logic [TAG_W-1:0] s1_tag_reg;

    always_comb
    begin
        s1_e1_next[0] = edge_t'(in_data.v1_x) - edge_t'(in_data.v0_x);
        s1_e1_next[1] = edge_t'(in_data.v1_y) - edge_t'(in_data.v0_y);
        s1_e1_next[2] = edge_t'(in_data.v1_z) - edge_t'(in_data.v0_z);
        s1_e2_next[0] = edge_t'(in_data.v2_x) - edge_t'(in_data.v0_x);
        s1_e2_next[1] = edge_t'(in_data.v2_y) - edge_t'(in_data.v0_y);
        s1_e2_next[2] = edge_t'(in_data.v2_z) - edge_t'(in_data.v0_z);
        s1_s_next[0]  = edge_t'(cfg.origin_x) - edge_t'(in_data.v0_x);
        s1_s_next[1]  = edge_t'(cfg.origin_y) - edge_t'(in_data.v0_y);
        s1_s_next[2]  = edge_t'(cfg.origin_z) - edge_t'(in_data.v0_z);
    end

    // ---------------- stage 2: cross product terms ----------------
    // p = dir x e2 from pa - pb, q = s x e1 from qa - qb
    prod_t s2_pa_reg [3], s2_pb_reg [3], s2_qa_reg [3], s2_qb_reg [3];
    prod_t s2_pa_next [3], s2_pb_next [3], s2_qa_next [3], s2_qb_next [3];
    edge_t s2_e1_reg [3], s2_s_reg [3];
    logic [TAG_W-1:0] s2_tag_reg;

    always_comb
    begin
        s2_pa_next[0] = prod_t'(cfg.dir_y) * prod_t'(s1_e2_reg[2]);
        s2_pb_next[0] = prod_t'(cfg.dir_z) * prod_t'(s1_e2_reg[1]);
        s2_pa_next[1] = prod_t'(cfg.dir_z) * prod_t'(s1_e2_reg[0]);
        s2_pb_next[1] = prod_t'(cfg.dir_x) * prod_t'(s1_e2_reg[2]);
        s2_pa_next[2] = prod_t'(cfg.dir_x) * prod_t'(s1_e2_reg[1]);
        s2_pb_next[2] = prod_t'(cfg.dir_y) * prod_t'(s1_e2_reg[0]);
        s2_qa_next[0] = prod_t'(s1_s_reg[1]) * prod_t'(s1_e1_reg[2]);
        s2_qb_next[0] = prod_t'(s1_s_reg[2]) * prod_t'(s1_e1_reg[1]);
        s2_qa_next[1] = prod_t'(s1_s_reg[2]) * prod_t'(s1_e1_reg[0]);
        s2_qb_next[1] = prod_t'(s1_s_reg[0]) * prod_t'(s1_e1_reg[2]);
        s2_qa_next[2] = prod_t'(s1_s_reg[0]) * prod_t'(s1_e1_reg[1]);
        s2_qb_next[2] = prod_t'(s1_s_reg[1]) * prod_t'(s1_e1_reg[0]);
    end

    // ---------------- stage 3: cross products ----------------
    crs_t  s3_p_reg [3], s3_q_reg [3];
    crs_t  s3_p_next [3], s3_q_next [3];
    edge_t s3_e1_reg [3], s3_s_reg [3];
    logic [TAG_W-1:0] s3_tag_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_p_next[i] = crs_t'(s2_pa_reg[i]) - crs_t'(s2_pb_reg[i]);
            s3_q_next[i] = crs_t'(s2_qa_reg[i]) - crs_t'(s2_qb_reg[i]);
        end
    end

    // ---------------- stage 4: dot product partials ----------------
    part_t s4_dh_reg [3], s4_dl_reg [3], s4_uh_reg [3], s4_ul_reg [3];
    part_t s4_vh_reg [3], s4_vl_reg [3];
    part_t s4_dh_next [3], s4_dl_next [3], s4_uh_next [3], s4_ul_next [3];
    part_t s4_vh_next [3], s4_vl_next [3];
    edge_t dir_e [3];
    logic [TAG_W-1:0] s4_tag_reg;

    always_comb
    begin
        dir_e[0] = edge_t'(cfg.dir_x);
        dir_e[1] = edge_t'(cfg.dir_y);
        dir_e[2] = edge_t'(cfg.dir_z);
        for (int i = 0; i < 3; i++)
        begin
            s4_dh_next[i] = mul_hi(s3_e1_reg[i], s3_p_reg[i]);
            s4_dl_next[i] = mul_lo(s3_e1_reg[i], s3_p_reg[i]);
            s4_uh_next[i] = mul_hi(s3_s_reg[i], s3_p_reg[i]);
            s4_ul_next[i] = mul_lo(s3_s_reg[i], s3_p_reg[i]);
            s4_vh_next[i] = mul_hi(dir_e[i], s3_q_reg[i]);
            s4_vl_next[i] = mul_lo(dir_e[i], s3_q_reg[i]);
        end
    end

    // ---------------- stage 5: det, u and v numerators ----------------
    dot_t s5_det_reg, s5_un_reg, s5_vn_reg;
    dot_t s5_det_next, s5_un_next, s5_vn_next;
    logic [TAG_W-1:0] s5_tag_reg;

    always_comb
    begin
        s5_det_next = dot3(s4_dh_reg[0], s4_dh_reg[1], s4_dh_reg[2],
                           s4_dl_reg[0], s4_dl_reg[1], s4_dl_reg[2]);
        s5_un_next  = dot3(s4_uh_reg[0], s4_uh_reg[1], s4_uh_reg[2],
                           s4_ul_reg[0], s4_ul_reg[1], s4_ul_reg[2]);
        s5_vn_next  = dot3(s4_vh_reg[0], s4_vh_reg[1], s4_vh_reg[2],
                           s4_vl_reg[0], s4_vl_reg[1], s4_vl_reg[2]);
    end

    // ---------------- stage 6: decision ----------------
    // negative det: the u/v inequalities flip instead of negating the numerators
    tri_out_t out_reg;
    tri_out_t out_next;
    dot_t     eps_s;
    usum_t    uv_sum;
    usum_t    det_x;
    logic     det_neg;
    logic     thr_fail;
    logic     bary_ok;

    always_comb
    begin
        eps_s   = dot_t'(cfg.det_epsilon);
        det_neg = s5_det_reg[DOT_W-1];
        uv_sum  = usum_t'(s5_un_reg) + usum_t'(s5_vn_reg);
        det_x   = usum_t'(s5_det_reg);
        if (cfg.cull_backfaces || !det_neg)
        begin
            thr_fail = s5_det_reg < eps_s;
        end
        else
        begin
            // |det| < eps with det negative
            thr_fail = s5_det_reg > -eps_s;
        end
        if (det_neg)
        begin
            bary_ok = (s5_un_reg <= 0) && (s5_un_reg >= s5_det_reg)
                   && (s5_vn_reg <= 0) && (uv_sum >= det_x);
        end
        else
        begin
            bary_ok = (s5_un_reg >= 0) && (s5_un_reg <= s5_det_reg)
                   && (s5_vn_reg >= 0) && (uv_sum <= det_x);
        end
        out_next.hit     = (s5_det_reg != 0) && !thr_fail && bary_ok;
        out_next.hit_tag = s5_tag_reg;
    end

    // ---------------- stage registers ----------------
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_e1_reg  <= s1_e1_next;
            s1_e2_reg  <= s1_e2_next;
            s1_s_reg   <= s1_s_next;
            s1_tag_reg <= in_data.tri_tag;
        end
        if (en[1])
        begin
            s2_pa_reg  <= s2_pa_next;
            s2_pb_reg  <= s2_pb_next;
            s2_qa_reg  <= s2_qa_next;
            s2_qb_reg  <= s2_qb_next;
            s2_e1_reg  <= s1_e1_reg;
            s2_s_reg   <= s1_s_reg;
            s2_tag_reg <= s1_tag_reg;
        end
        if (en[2])
        begin
            s3_p_reg   <= s3_p_next;
            s3_q_reg   <= s3_q_next;
            s3_e1_reg  <= s2_e1_reg;
            s3_s_reg   <= s2_s_reg;
            s3_tag_reg <= s2_tag_reg;
        end
        if (en[3])
        begin
            s4_dh_reg  <= s4_dh_next;
            s4_dl_reg  <= s4_dl_next;
            s4_uh_reg  <= s4_uh_next;
            s4_ul_reg  <= s4_ul_next;
            s4_vh_reg  <= s4_vh_next;
            s4_vl_reg  <= s4_vl_next;
            s4_tag_reg <= s3_tag_reg;
        end
        if (en[4])
        begin
            s5_det_reg <= s5_det_next;
            s5_un_reg  <= s5_un_next;
            s5_vn_reg  <= s5_vn_next;
            s5_tag_reg <= s4_tag_reg;
        end
        if (en[5])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

[rtl/ray_triangle_hit_test_top.sv]
`timescale 1ns / 1ps
// Throughput: one triangle per cycle while out_stall is low, set by six register
//   stages; the widest step is the split dot product multiply in stage four.
// A stalled output freezes only the stages that have no bubble ahead of them.
// Reset: valid bits cleared, ray registers return to origin 0, dir (0,0,1.0),
//   no culling, threshold 17.
// ----------------------------------------------------------------------------
// ray_triangle_hit_test_top
// Moller-Trumbore ray/triangle hit test, fixed point, no division. Holds the
// ray in configuration registers and tests a stream of triangles against it.
// ----------------------------------------------------------------------------
`include "ray_triangle_hit_test_top_macros.svh"

module ray_triangle_hit_test_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [rth_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rth_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  rth_pkg::tri_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output rth_pkg::tri_out_t               out_data
);
    import rth_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X: cfg_next.origin_x       = coord_t'(cfg_data[COORD_W-1:0]);
                CFG_ORIGIN_Y: cfg_next.origin_y       = coord_t'(cfg_data[COORD_W-1:0]);
                CFG_ORIGIN_Z: cfg_next.origin_z       = coord_t'(cfg_data[COORD_W-1:0]);
                CFG_DIR_X:    cfg_next.dir_x          = coord_t'(cfg_data[COORD_W-1:0]);
                CFG_DIR_Y:    cfg_next.dir_y          = coord_t'(cfg_data[COORD_W-1:0]);
                CFG_DIR_Z:    cfg_next.dir_z          = coord_t'(cfg_data[COORD_W-1:0]);
                CFG_CULL:     cfg_next.cull_backfaces = cfg_data[0];
                CFG_EPSILON:  cfg_next.det_epsilon    = cfg_data[EPS_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{origin_x: '0, origin_y: '0, origin_z: '0,
                         dir_x: '0, dir_y: '0, dir_z: DIR_Z_RESET,
                         cull_backfaces: 1'b0, det_epsilon: EPS_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rth_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    logic               dir_z_wr;
    logic               eps_wr;
    logic [COORD_W-1:0] cfg_coord;

    assign dir_z_wr  = cfg_write && (cfg_index == CFG_DIR_Z);
    assign eps_wr    = cfg_write && (cfg_index == CFG_EPSILON);
    assign cfg_coord = cfg_data[COORD_W-1:0];

    // input backs up only when every stage is full behind a stalled output beat
    `RTH_ASSERT_NOW(a_stall_when_full, in_stall, out_valid && out_stall, "stall with room")
    `RTH_ASSERT_NEXT(a_dir_z_write, dir_z_wr, cfg_reg.dir_z == $past(cfg_coord), "dir_z lost")
    `RTH_ASSERT_NEXT(a_eps_write, eps_wr, cfg_reg.det_epsilon == $past(cfg_data), "eps lost")

endmodule
